// File: sv/asa_pkg.sv
// Package for the aligned stack allocator: widths, command and status codes,
// and the request and result beat types. Depends on nothing.
package asa_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int ALIGN_BYTES = 32;
  localparam int PTR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int ALIGN_W = (ALIGN_BYTES > 1) ? $clog2(ALIGN_BYTES) : 1;

  localparam int ADDR_W = 32;
  localparam int LEN_W = 33;
  localparam int COUNT_W = 7;
  localparam int CFG_INDEX_W = 2;

  localparam logic [1:0] CMD_ALLOC = 2'd0;
  localparam logic [1:0] CMD_FREE = 2'd1;
  localparam logic [1:0] CMD_INIT = 2'd2;
  localparam logic [1:0] CMD_CLEAR = 2'd3;

  localparam logic [2:0] STAT_OK = 3'd0;
  localparam logic [2:0] STAT_NOT_INIT = 3'd1;
  localparam logic [2:0] STAT_BAD_LAYOUT = 3'd2;
  localparam logic [2:0] STAT_BAD_REQUEST = 3'd3;
  localparam logic [2:0] STAT_ALREADY = 3'd4;
  localparam logic [2:0] STAT_EXHAUSTED = 3'd5;
  localparam logic [2:0] STAT_EMPTY = 3'd6;

  localparam logic [CFG_INDEX_W-1:0] REG_BASE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SIZE = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_LIMIT = 2'd2;

  typedef struct packed {
    logic [1:0] command;
    logic [LEN_W-1:0] request_length;
  } request_t;

  typedef struct packed {
    logic [2:0] status;
    logic [ADDR_W-1:0] block_address;
    logic [ADDR_W-1:0] block_length;
    logic [ADDR_W-1:0] top_pointer;
    logic [COUNT_W-1:0] free_slots;
  } result_t;

endpackage

// File: sv/aligned_stack_allocator_top.sv
// Aligned stack allocator: LIFO region allocator with the length stack held
// in a synchronous memory. Depends on asa_pkg.
//
// Channel  | Handshake                  | Beat
// request  | start, accepted when !busy | request (command, request_length)
// result   | done, one cycle, no stall  | result (status, addresses, slots)
// config   | cfg_valid / cfg_ready      | cfg_index, cfg_data
//
// On accept, the command and the top stack entry are registered and the
// block enters EXEC; leaving EXEC updates state and writes the entry on
// allocate. The result beat shows in the cycle after that, while a new
// command may already be accepted. Reset is synchronous; the stack memory
// is not cleared. Configuration is always ready.
module aligned_stack_allocator_top (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  asa_pkg::request_t request,
  output logic done,
  output asa_pkg::result_t result,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [asa_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [asa_pkg::ADDR_W-1:0] cfg_data
);
  import asa_pkg::*;

  localparam logic STATE_IDLE = 1'b0;
  localparam logic STATE_EXEC = 1'b1;

  logic state;
  logic [ADDR_W-1:0] length_stack [STACK_DEPTH];
  logic [ADDR_W-1:0] rd_data;
  request_t req;

  logic [ADDR_W-1:0] reg_base;
  logic [ADDR_W-1:0] reg_size;
  logic [COUNT_W-1:0] reg_limit;

  logic [COUNT_W-1:0] live_count, live_count_next;
  logic [ADDR_W-1:0] top_address, top_address_next;
  logic is_ready, is_ready_next;
  logic [ADDR_W-1:0] latched_base, latched_base_next;
  logic [ADDR_W-1:0] latched_size, latched_size_next;
  logic [COUNT_W-1:0] latched_limit, latched_limit_next;

  logic wr_en;
  logic [2:0] status;
  logic [ADDR_W-1:0] addr;
  logic [ADDR_W-1:0] blen;
  logic [ADDR_W-1:0] room;
  logic accept;

  assign accept = start && (state == STATE_IDLE);
  assign busy = (state == STATE_EXEC);
  assign cfg_ready = 1'b1;
  assign room = latched_size - top_address;

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_base <= '0;
      reg_size <= '0;
      reg_limit <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BASE: reg_base <= cfg_data;
        REG_SIZE: reg_size <= cfg_data;
        REG_LIMIT: reg_limit <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req <= request;
      rd_data <= length_stack[PTR_W'(live_count - COUNT_W'(1))];
    end
    if (wr_en) begin
      length_stack[live_count[PTR_W-1:0]] <= req.request_length[ADDR_W-1:0];
    end
  end

  always_comb begin
    live_count_next = live_count;
    top_address_next = top_address;
    is_ready_next = is_ready;
    latched_base_next = latched_base;
    latched_size_next = latched_size;
    latched_limit_next = latched_limit;
    wr_en = 1'b0;
    status = STAT_OK;
    addr = '0;
    blen = '0;
    if (state == STATE_EXEC) begin
      case (req.command)
        CMD_INIT: begin
          if (is_ready) begin
            status = STAT_ALREADY;
          end else if (reg_base == '0 || reg_base[ALIGN_W-1:0] != '0 ||
                       reg_size < reg_base) begin
            status = STAT_BAD_LAYOUT;
          end else begin
            latched_base_next = reg_base;
            latched_size_next = reg_size;
            latched_limit_next = reg_limit;
            top_address_next = reg_base;
            live_count_next = '0;
            is_ready_next = 1'b1;
          end
        end
        CMD_CLEAR: begin
          live_count_next = '0;
          top_address_next = '0;
          is_ready_next = 1'b0;
          latched_base_next = '0;
          latched_size_next = '0;
          latched_limit_next = '0;
        end
        CMD_ALLOC: begin
          if (!is_ready) begin
            status = STAT_NOT_INIT;
          end else if (req.request_length[LEN_W-1] ||
                       req.request_length[ALIGN_W-1:0] != '0) begin
            status = STAT_BAD_REQUEST;
          end else if (live_count >= latched_limit ||
                       live_count >= COUNT_W'(STACK_DEPTH)) begin
            status = STAT_EXHAUSTED;
          end else if (top_address > latched_size ||
                       req.request_length[ADDR_W-1:0] > room) begin
            status = STAT_EXHAUSTED;
          end else begin
            addr = top_address;
            blen = req.request_length[ADDR_W-1:0];
            top_address_next = top_address + req.request_length[ADDR_W-1:0];
            live_count_next = live_count + COUNT_W'(1);
            wr_en = 1'b1;
          end
        end
        default: begin
          if (!is_ready) begin
            status = STAT_NOT_INIT;
          end else if (live_count == '0) begin
            status = STAT_EMPTY;
          end else if (top_address < rd_data) begin
            status = STAT_BAD_LAYOUT;
          end else begin
            live_count_next = live_count - COUNT_W'(1);
            top_address_next = top_address - rd_data;
            addr = top_address - rd_data;
            blen = rd_data;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_IDLE;
      done <= 1'b0;
      live_count <= '0;
      top_address <= '0;
      is_ready <= 1'b0;
      latched_base <= '0;
      latched_size <= '0;
      latched_limit <= '0;
    end else begin
      done <= (state == STATE_EXEC);
      case (state)
        STATE_IDLE: begin
          if (accept) begin
            state <= STATE_EXEC;
          end
        end
        default: begin
          state <= STATE_IDLE;
          live_count <= live_count_next;
          top_address <= top_address_next;
          is_ready <= is_ready_next;
          latched_base <= latched_base_next;
          latched_size <= latched_size_next;
          latched_limit <= latched_limit_next;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == STATE_EXEC) begin
      result.status <= status;
      result.block_address <= addr;
      result.block_length <= blen;
      result.top_pointer <= top_address_next;
      result.free_slots <= (latched_limit_next >= live_count_next) ?
                           (latched_limit_next - live_count_next) : '0;
    end
  end

endmodule
